// ===== rtl/tlis_pkg.sv =====
// Shared types, constants and tick update function for the tube line interlock sequencer.
package tlis_pkg;

	localparam int WordW      = 14;
	localparam int TicksW     = 9;
	localparam int LimitW     = 9;
	localparam int FifoDepth  = 4;
	localparam int ApbDataW   = 32;
	localparam int ApbAddrW   = 3;

	localparam logic [LimitW-1:0] LimitReset = 9'd300;

	// Register addresses on the configuration port
	localparam logic [ApbAddrW-1:0] AddrRollingLimit = 3'd0;

	// Sensor bits
	localparam logic [WordW-1:0] SShootAEnd  = 14'h0001;
	localparam logic [WordW-1:0] SHomeA      = 14'h0002;
	localparam logic [WordW-1:0] SShootBEnd  = 14'h0004;
	localparam logic [WordW-1:0] SHomeB      = 14'h0008;
	localparam logic [WordW-1:0] SRail       = 14'h0040;
	localparam logic [WordW-1:0] SRoll       = 14'h0080;
	localparam logic [WordW-1:0] SSweep      = 14'h0100;
	localparam logic [WordW-1:0] SEntry      = 14'h0400;
	localparam logic [WordW-1:0] SConvB      = 14'h0800;
	localparam logic [WordW-1:0] STargetRdy  = 14'h1000;

	// Actuator bits
	localparam logic [WordW-1:0] AConvC      = 14'h0001;
	localparam logic [WordW-1:0] AConvA      = 14'h0004;
	localparam logic [WordW-1:0] ABRecoil    = 14'h0008;
	localparam logic [WordW-1:0] AConvB      = 14'h0010;
	localparam logic [WordW-1:0] AShootA     = 14'h0020;
	localparam logic [WordW-1:0] AShootB     = 14'h0080;
	localparam logic [WordW-1:0] ARoll       = 14'h0100;
	localparam logic [WordW-1:0] ASweep      = 14'h0200;
	localparam logic [WordW-1:0] AFeedB      = 14'h0400;
	localparam logic [WordW-1:0] AARecoil    = 14'h0800;

	typedef struct packed {
		logic [WordW-1:0]  drive;
		logic              shoot_a;
		logic              shoot_b;
		logic              ready_a;
		logic              ready_b;
		logic [TicksW-1:0] ticks;
	} state_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             last;
	} result_t;

	typedef struct packed {
		state_t           nxt;
		logic             extra;
		logic [WordW-1:0] mid_word;
	} tick_t;

	// Toggle a bit only when it was set at the start of the tick
	function automatic logic [WordW-1:0] cond_clear(input logic [WordW-1:0] cur,
		input logic [WordW-1:0] start, input logic [WordW-1:0] bit_mask);
		logic [WordW-1:0] r;
		r = cur;
		if ((start & bit_mask) != '0) r = cur ^ bit_mask;
		return r;
	endfunction

	function automatic tick_t tick_update(input logic [WordW-1:0] s, input state_t st,
		input logic [LimitW-1:0] limit);
		logic [WordW-1:0] v;
		logic [WordW-1:0] start;
		logic [TicksW:0]  cnt;
		tick_t            t;
		start = st.drive;
		v = st.drive;
		t.nxt = st;
		t.extra = 1'b0;
		t.mid_word = st.drive;
		cnt = {1'b0, st.ticks} + 1'b1;

		if ((s & SEntry) != '0) v = v | AConvA;
		if ((s & SSweep) != '0) begin
			v = v | ASweep | AFeedB;
			v = cond_clear(v, start, AConvA);
		end
		if ((s & SConvB) != '0) begin
			v = cond_clear(v, start, ASweep);
			v = cond_clear(v, start, AFeedB);
			v = v | AConvB;
		end

		if (((s & SRoll) != '0) && st.ready_a) begin
			v = cond_clear(v, start, AConvB);
			v = v | ARoll;
			if (cnt > {1'b0, limit}) begin
				t.nxt.ticks = '0;
				v = v ^ ARoll;
				t.mid_word = v;
				t.extra = 1'b1;
				t.nxt.shoot_a = 1'b1;
				t.nxt.ready_a = 1'b0;
			end else begin
				t.nxt.ticks = cnt[TicksW-1:0];
			end
		end

		if (t.nxt.shoot_a) begin
			v = v | AConvC;
			v = cond_clear(v, start, ARoll);
			if ((s & SShootAEnd) == '0) begin
				v = v | AARecoil | AShootA;
			end else begin
				v = cond_clear(v, start, AARecoil);
				v = cond_clear(v, start, AShootA);
				t.nxt.shoot_a = 1'b0;
			end
		end

		if (((s & SRail) != '0) && t.nxt.ready_b) begin
			v = cond_clear(v, start, AConvC);
			if ((s & STargetRdy) != '0) t.nxt.shoot_b = 1'b1;
		end

		if (t.nxt.shoot_b) begin
			if ((s & SShootBEnd) == '0) begin
				v = v | AShootB;
			end else begin
				v = cond_clear(v, start, AShootB);
				t.nxt.shoot_b = 1'b0;
				t.nxt.ready_b = 1'b0;
			end
		end

		if (((s & SHomeA) == '0) && !t.nxt.shoot_a) begin
			v = v | AARecoil;
		end else begin
			v = cond_clear(v, start, AARecoil);
			t.nxt.ready_a = 1'b1;
		end

		if (((s & SHomeB) == '0) && !t.nxt.shoot_b) begin
			v = v | AShootB | ABRecoil;
		end else begin
			v = cond_clear(v, start, AShootB);
			v = cond_clear(v, start, ABRecoil);
			t.nxt.ready_b = 1'b1;
		end

		t.nxt.drive = v;
		return t;
	endfunction

endpackage

// ===== rtl/tlis_ifs.sv =====
// Stream interfaces for sensor ticks and actuator words.
interface tlis_in_if;
	logic                        valid;
	logic                        ready;
	logic [tlis_pkg::WordW-1:0]  sensor_word;
	modport source (output valid, output sensor_word, input ready);
	modport sink (input valid, input sensor_word, output ready);
endinterface

interface tlis_out_if;
	logic                        valid;
	logic                        ready;
	logic [tlis_pkg::WordW-1:0]  actuator_word;
	logic                        last_of_tick;
	modport source (output valid, output actuator_word, output last_of_tick, input ready);
	modport sink (input valid, input actuator_word, input last_of_tick, output ready);
endinterface

// ===== rtl/tlis_result_fifo.sv =====
// Small result queue taking one or two actuator words per push.
module tlis_result_fifo #(
	parameter int Depth = tlis_pkg::FifoDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               push_two,
	input  tlis_pkg::result_t  data_a,
	input  tlis_pkg::result_t  data_b,
	output logic               room,
	tlis_out_if.source         actuator
);
	import tlis_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	result_t           mem_q [Depth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [CntW-1:0]   count_q;
	logic [PtrW-1:0]   wr_next1;
	logic [PtrW-1:0]   wr_next2;
	logic              pop;
	logic [CntW-1:0]   push_n;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] r;
		if (p == PtrW'(Depth - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	assign wr_next1 = ptr_inc(wr_q);
	assign wr_next2 = ptr_inc(wr_next1);
	assign pop = actuator.valid && actuator.ready;
	assign push_n = push ? (push_two ? CntW'(2) : CntW'(1)) : '0;
	assign room = (count_q <= CntW'(Depth - 2));

	assign actuator.valid         = (count_q != '0);
	assign actuator.actuator_word = mem_q[rd_q].word;
	assign actuator.last_of_tick  = mem_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= data_a;
			if (push_two) mem_q[wr_next1] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= push_two ? wr_next2 : wr_next1;
			if (pop) rd_q <= ptr_inc(rd_q);
			count_q <= count_q + push_n - (pop ? CntW'(1) : CntW'(0));
		end
	end

endmodule

// ===== rtl/tube_line_interlock_sequencer.sv =====
// Top level of the tube line interlock sequencer: input stage, tick logic, config port.
// Path: a sensor word is held in the input stage register, and once the queue has room for two
// words its tick is written into the result queue, from which the first actuator word is offered.
// Throughput: one tick per cycle while ticks give one word each and the queue keeps room; a rolling
// timeout tick gives two words, which leave the output one after the other.
// Reset (arst_n low, asynchronous): drive word, flags and rolling counter clear,
// rolling_limit returns to 300 and the result queue empties.
module tube_line_interlock_sequencer #(
	parameter int FifoDepth = tlis_pkg::FifoDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tlis_in_if.sink                         sensor,
	tlis_out_if.source                      actuator,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tlis_pkg::ApbAddrW-1:0]   paddr,
	input  logic [tlis_pkg::ApbDataW-1:0]   pwdata,
	output logic [tlis_pkg::ApbDataW-1:0]   prdata,
	output logic                            pready
);
	import tlis_pkg::*;

	// Input stage: one sensor word waiting for the tick logic
	logic              valid_s1;
	logic [WordW-1:0]  sensor_s1;

	// Interlock state carried from tick to tick
	state_t            state_q;
	logic [LimitW-1:0] limit_q;

	tick_t             tick;
	logic              room;
	logic              advance;
	logic              cfg_wr;
	result_t           res_a;
	result_t           res_b;

	// Configuration port: no wait states; writes land on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ApbAddrW-1] == AddrRollingLimit[ApbAddrW-1]);
	assign prdata = (paddr[ApbAddrW-1] == AddrRollingLimit[ApbAddrW-1])
		? ApbDataW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LimitReset;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LimitW-1:0];
		end
	end

	// Advance the held tick once the queue can take two words, whatever the tick yields
	assign advance = valid_s1 && room;
	assign sensor.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.ready && sensor.valid) sensor_s1 <= sensor.sensor_word;
	end

	// Whole interlock update for one tick, from the held sensor word and current state
	assign tick = tick_update(sensor_s1, state_q, limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= tick.nxt;
		end
	end

	// A timeout tick pushes the intermediate word first, then the final one
	always_comb begin
		if (tick.extra) begin
			res_a.word = tick.mid_word;
			res_a.last = 1'b0;
		end else begin
			res_a.word = tick.nxt.drive;
			res_a.last = 1'b1;
		end
		res_b.word = tick.nxt.drive;
		res_b.last = 1'b1;
	end

	tlis_result_fifo #(
		.Depth (FifoDepth)
	) u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.push_two (tick.extra),
		.data_a   (res_a),
		.data_b   (res_b),
		.room     (room),
		.actuator (actuator)
	);

endmodule
